// File: src/ac4toc_pkg.sv
package ac4toc_pkg;

    // header geometry
    localparam int HdrBytes   = 10;
    localparam int HdrBits    = HdrBytes * 8;
    localparam int QueueDepth = 2;

    // sync word and length escape
    localparam logic [7:0] SYNC_B0     = 8'hAC;
    localparam logic [7:0] SYNC_B1_A   = 8'h40;
    localparam logic [7:0] SYNC_B1_B   = 8'h41;
    localparam logic [7:0] LEN_ESCAPE  = 8'hFF;

    // frame rate index limit
    localparam logic [3:0] TOP_INDEX   = 4'd13;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_BAD_441   = 2'd3;

    // samples per frame at 44.1k
    localparam logic [11:0] SPF_441 = 12'd2048;

    // one decode job handed from front to back
    typedef struct packed {
        logic               short_frame;
        logic [HdrBits-1:0] hdr;
    } job_t;

    // samples per frame at 48k by frame rate index
    function automatic logic [11:0] spf_48k(input logic [3:0] idx);
        logic [11:0] spf;
        case (idx)
            4'd0:    spf = 12'd1920;
            4'd1:    spf = 12'd1920;
            4'd2:    spf = 12'd2048;
            4'd3:    spf = 12'd1536;
            4'd4:    spf = 12'd1536;
            4'd5:    spf = 12'd960;
            4'd6:    spf = 12'd960;
            4'd7:    spf = 12'd1024;
            4'd8:    spf = 12'd768;
            4'd9:    spf = 12'd768;
            4'd10:   spf = 12'd512;
            4'd11:   spf = 12'd384;
            4'd12:   spf = 12'd384;
            4'd13:   spf = 12'd2048;
            default: spf = 12'd0;
        endcase
        return spf;
    endfunction

endpackage

// File: src/ac4toc_if.sv
// byte channel into the parser
interface ac4toc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       frame_start;
    logic       frame_end;

    modport source (output valid, output byte_value, output frame_start, output frame_end,
                    input ready);
    modport sink   (input valid, input byte_value, input frame_start, input frame_end,
                    output ready);
endinterface

// header result channel out of the parser
interface ac4toc_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        is_sync_frame;
    logic [9:0]  seq_number;
    logic        rate_is_48k;
    logic [11:0] frame_samples;

    modport source (output valid, output status, output is_sync_frame,
                    output seq_number, output rate_is_48k, output frame_samples,
                    input ready);
    modport sink   (input valid, input status, input is_sync_frame,
                    input seq_number, input rate_is_48k, input frame_samples,
                    output ready);
endinterface

// File: src/ac4toc_front.sv
module ac4toc_front import ac4toc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    ac4toc_byte_if.sink         bytes,
    input  logic                queue_full,
    output logic                push,
    output job_t                job
);

    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;
    logic       done_reg;
    logic       done_next;
    logic [7:0] store_reg [HdrBytes-1];

    logic       take;
    logic [3:0] cnt_eff;
    logic       done_eff;
    logic       active;
    logic       last_byte;

    assign bytes.ready = !queue_full;
    assign take        = bytes.valid && bytes.ready;

    // frame start restarts the count before the byte is taken
    always_comb
    begin
        cnt_eff   = bytes.frame_start ? 4'd0 : cnt_reg;
        done_eff  = bytes.frame_start ? 1'b0 : done_reg;
        active    = take && !done_eff;
        last_byte = (cnt_eff == 4'(HdrBytes - 1));
        push      = active && (last_byte || bytes.frame_end);
    end

    // job assembly: stored bytes plus the byte in transfer
    always_comb
    begin
        job.short_frame = !last_byte;
        for (int i = 0; i < HdrBytes - 1; i++)
        begin
            job.hdr[HdrBits-1-8*i -: 8] = store_reg[i];
        end
        job.hdr[7:0] = bytes.byte_value;
    end

    // next count and wait state
    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (take)
        begin
            cnt_next  = cnt_eff + {3'd0, active};
            done_next = done_eff || push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 4'd0;
            done_reg <= 1'b1;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // header byte store
    always_ff @(posedge clk)
    begin
        if (active && (cnt_eff < 4'(HdrBytes - 1)))
        begin
            store_reg[cnt_eff] <= bytes.byte_value;
        end
    end

endmodule

// File: src/ac4toc_queue.sv
module ac4toc_queue import ac4toc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic pop_valid,
    output job_t pop_job,
    input  logic pop
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    job_t       entry_reg [QueueDepth];

    assign full      = (count_reg == 2'(QueueDepth));
    assign pop_valid = (count_reg != 2'd0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // entry write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: src/ac4toc_back.sv
module ac4toc_back import ac4toc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  job_t          job,
    output logic          pop,
    ac4toc_res_if.source  results
);

    logic        valid_reg;
    logic        valid_next;
    logic [1:0]  status_reg;
    logic        sync_reg;
    logic [9:0]  seq_reg;
    logic        rate_reg;
    logic [11:0] spf_reg;

    logic [7:0]  h0, h1, h2, h3, h4, h5, h6;
    logic        sync;
    logic        esc;
    logic [23:0] plen;
    logic [26:0] limit;
    logic [23:0] win;
    logic [9:0]  seq;
    logic        wait_flag;
    logic [2:0]  wait_bits;
    logic        rate;
    logic [3:0]  idx;
    logic [1:0]  status;
    logic [11:0] spf;

    // field end check against the payload bound, sync frames only
    function automatic logic fits(input logic bounded, input logic [26:0] lim,
                                  input logic [4:0] end_pos);
        return !bounded || ({22'd0, end_pos} <= lim);
    endfunction

    // sync word and payload length
    always_comb
    begin
        h0    = job.hdr[79:72];
        h1    = job.hdr[71:64];
        h2    = job.hdr[63:56];
        h3    = job.hdr[55:48];
        h4    = job.hdr[47:40];
        h5    = job.hdr[39:32];
        h6    = job.hdr[31:24];
        sync  = (h0 == SYNC_B0) && ((h1 == SYNC_B1_A) || (h1 == SYNC_B1_B));
        esc   = (h2 == LEN_ESCAPE) && (h3 == LEN_ESCAPE);
        plen  = esc ? {h4, h5, h6} : {8'd0, h2, h3};
        limit = {plen, 3'b000};
        if (!sync)
        begin
            win = job.hdr[79:56];
        end
        else if (esc)
        begin
            win = job.hdr[23:0];
        end
        else
        begin
            win = job.hdr[47:24];
        end
    end

    // table of contents fields, msb first in the window
    always_comb
    begin
        seq       = fits(sync, limit, 5'd12) ? win[21:12] : 10'd0;
        wait_flag = fits(sync, limit, 5'd13) && win[11];
        wait_bits = fits(sync, limit, 5'd16) ? win[10:8] : 3'd0;
        if (!wait_flag)
        begin
            rate = fits(sync, limit, 5'd14) && win[10];
            idx  = fits(sync, limit, 5'd18) ? win[9:6] : 4'd0;
        end
        else if (wait_bits != 3'd0)
        begin
            rate = fits(sync, limit, 5'd19) && win[5];
            idx  = fits(sync, limit, 5'd23) ? win[4:1] : 4'd0;
        end
        else
        begin
            rate = fits(sync, limit, 5'd17) && win[7];
            idx  = fits(sync, limit, 5'd21) ? win[6:3] : 4'd0;
        end
    end

    // index checks and rate table lookup
    always_comb
    begin
        if (idx > TOP_INDEX)
        begin
            status = ST_BAD_INDEX;
        end
        else if (!rate && (idx != TOP_INDEX))
        begin
            status = ST_BAD_441;
        end
        else
        begin
            status = ST_OK;
        end
        if (status == ST_OK)
        begin
            spf = rate ? spf_48k(idx) : SPF_441;
        end
        else
        begin
            spf = 12'd0;
        end
    end

    // output register handshake
    assign pop = job_valid && (!valid_reg || results.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (job.short_frame)
            begin
                status_reg <= ST_SHORT;
                sync_reg   <= 1'b0;
                seq_reg    <= 10'd0;
                rate_reg   <= 1'b0;
                spf_reg    <= 12'd0;
            end
            else
            begin
                status_reg <= status;
                sync_reg   <= sync;
                seq_reg    <= seq;
                rate_reg   <= rate;
                spf_reg    <= spf;
            end
        end
    end

    assign results.valid         = valid_reg;
    assign results.status        = status_reg;
    assign results.is_sync_frame = sync_reg;
    assign results.seq_number    = seq_reg;
    assign results.rate_is_48k   = rate_reg;
    assign results.frame_samples = spf_reg;

endmodule

// File: src/ac4_toc_header_parser.sv
// AC-4 table-of-contents header parser. Frame bytes come in one per transfer on the
// byte channel, with frame_start on the first byte of a frame and frame_end on the last
// byte of the buffer. The parser keeps the first ten bytes and gives one result per frame:
// the decoded header on the tenth byte, or a short-frame status if frame_end comes first.
// Bytes before a frame start, and after the result of a frame, are taken and dropped.
// A byte is taken every cycle while the queue is not full; the front stores bytes and hands
// finished headers to a two-entry queue, the back decodes one header per cycle when its
// output register is free or being read, results pass the queue and that register, and the
// byte channel only stalls when the queue is full because results are not being taken.
module ac4_toc_header_parser import ac4toc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ac4toc_byte_if.sink   bytes,
    ac4toc_res_if.source  results
);

    logic queue_full;
    logic push;
    job_t push_job;
    logic job_valid;
    job_t job;
    logic pop;

    // byte intake and header capture
    ac4toc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    // job queue between front and back
    ac4toc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop_valid (job_valid),
        .pop_job   (job),
        .pop       (pop)
    );

    // header decode and result register
    ac4toc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .pop       (pop),
        .results   (results)
    );

endmodule

// File: dv/ac4toc_tb_pkg.sv
`timescale 1ns / 1ps
package ac4toc_tb_pkg;
    import ac4toc_pkg::*;

    // only the first few bad results are printed in full
    localparam int MaxReports = 10;

    typedef logic [7:0] hdr_bytes_t [HdrBytes];

    // one decoded header as it leaves the parser
    typedef struct packed {
        logic [1:0]  status;
        logic        is_sync;
        logic [9:0]  seq_count;
        logic        rate_48k;
        logic [11:0] spf;
    } header_t;

    // how the header bytes of a stimulus frame are laid out
    typedef enum {FORM_SYNC_PLAIN, FORM_SYNC_ESCAPED, FORM_RAW} header_form_t;

    // samples per frame at 48k; indexes above the top one never get here
    function automatic logic [11:0] samples_at_48k(input logic [3:0] idx);
        case (idx)
            4'd0, 4'd1:  return 12'd1920;
            4'd2, 4'd13: return 12'd2048;
            4'd3, 4'd4:  return 12'd1536;
            4'd5, 4'd6:  return 12'd960;
            4'd7:        return 12'd1024;
            4'd8, 4'd9:  return 12'd768;
            4'd10:       return 12'd512;
            default:     return 12'd384;
        endcase
    endfunction

    class header_scoreboard;
        hdr_bytes_t captured;
        logic [3:0] taken_count;
        bit         waiting;
        header_t    pending[$];
        int         bytes_taken;
        int         headers_checked;
        int         failures;
        int         sync_seen;
        int         status_seen[4];

        function new();
            taken_count = '0;
            waiting = 1'b1;
            bytes_taken = 0;
            headers_checked = 0;
            failures = 0;
            sync_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
            foreach (captured[i]) captured[i] = '0;
        endfunction

        // n bits msb first at bit pos after byte base, zero past the payload bound
        function int unsigned field_bits(int unsigned base, int unsigned pos, int unsigned n,
                                         bit bounded, int unsigned limit);
            int unsigned v;
            int unsigned bitpos;
            v = 0;
            if (bounded && pos + n > limit)
                return 0;
            for (int unsigned i = 0; i < n; i++)
            begin
                bitpos = base * 8 + pos + i;
                v = v << 1;
                if ((bitpos >> 3) < HdrBytes)
                    v = v | captured[bitpos >> 3][7 - (bitpos & 7)];
            end
            return v;
        endfunction

        // decode the ten captured bytes
        function header_t decode_header();
            header_t     r;
            bit          sync;
            int unsigned base;
            int unsigned limit;
            int unsigned pos;
            int unsigned plen;
            int unsigned wait_count;
            int unsigned seq;
            int unsigned rate;
            int unsigned idx;
            sync = captured[0] == SYNC_B0 &&
                   (captured[1] == SYNC_B1_A || captured[1] == SYNC_B1_B);
            base = 0;
            limit = 0;
            pos = 2;
            // sync frames carry a plain or an escaped payload length
            if (sync)
            begin
                if (captured[2] == LEN_ESCAPE && captured[3] == LEN_ESCAPE)
                begin
                    plen = {captured[4], captured[5], captured[6]};
                    base = 7;
                end
                else
                begin
                    plen = {captured[2], captured[3]};
                    base = 4;
                end
                limit = plen * 8;
            end
            // table of contents fields
            seq = field_bits(base, pos, 10, sync, limit);
            pos += 10;
            if (field_bits(base, pos, 1, sync, limit) != 0)
            begin
                pos += 1;
                wait_count = field_bits(base, pos, 3, sync, limit);
                pos += 3;
                if (wait_count != 0)
                    pos += 2;
            end
            else
                pos += 1;
            rate = field_bits(base, pos, 1, sync, limit);
            pos += 1;
            idx = field_bits(base, pos, 4, sync, limit);
            // status and rate lookup
            r.status = ST_OK;
            r.is_sync = sync;
            r.seq_count = seq[9:0];
            r.rate_48k = rate[0];
            r.spf = '0;
            if (idx > TOP_INDEX)
                r.status = ST_BAD_INDEX;
            else if (rate == 0 && idx != TOP_INDEX)
                r.status = ST_BAD_441;
            if (r.status == ST_OK)
                r.spf = (rate != 0) ? samples_at_48k(idx[3:0]) : SPF_441;
            return r;
        endfunction

        // track one accepted byte and queue the header it completes, if any
        function void take_byte(logic [7:0] b, bit start, bit last);
            header_t short_hdr;
            short_hdr = '0;
            short_hdr.status = ST_SHORT;
            if (start)
            begin
                taken_count = '0;
                waiting = 1'b0;
            end
            if (waiting)
                return;
            bytes_taken++;
            if (taken_count < HdrBytes)
                captured[taken_count] = b;
            taken_count++;
            if (taken_count >= HdrBytes)
            begin
                waiting = 1'b1;
                pending.push_back(decode_header());
            end
            else if (last)
            begin
                waiting = 1'b1;
                pending.push_back(short_hdr);
            end
        endfunction

        // compare one result transfer with the oldest pending header
        function void check_header(header_t got);
            header_t want;
            if (pending.size() == 0)
            begin
                failures++;
                if (failures <= MaxReports)
                    $display("unexpected header: status=%0d sync=%0d seq=%0d r48=%0d spf=%0d",
                             got.status, got.is_sync, got.seq_count, got.rate_48k, got.spf);
                return;
            end
            want = pending.pop_front();
            headers_checked++;
            status_seen[want.status]++;
            if (want.is_sync)
                sync_seen++;
            if (got.status !== want.status || got.is_sync !== want.is_sync ||
                got.seq_count !== want.seq_count || got.rate_48k !== want.rate_48k ||
                got.spf !== want.spf)
            begin
                failures++;
                if (failures <= MaxReports)
                begin
                    $display("header %0d mismatch", headers_checked);
                    $display("  want status=%0d sync=%0d seq=%0d r48=%0d spf=%0d",
                             want.status, want.is_sync, want.seq_count, want.rate_48k,
                             want.spf);
                    $display("  got  status=%0d sync=%0d seq=%0d r48=%0d spf=%0d",
                             got.status, got.is_sync, got.seq_count, got.rate_48k, got.spf);
                end
            end
        endfunction
    endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ac4toc_pkg::*;
    import ac4toc_tb_pkg::*;

    localparam int ByteTarget  = 1750;
    localparam int HoldCycles  = 400;
    localparam int DrainCycles = 20;
    localparam int CycleLimit  = 400000;

    logic clk = 1'b0;
    logic rst_n;
    bit   hold_off = 1'b0;
    int   phase = 0;
    int   cycles = 0;
    int   stall_cycles = 0;
    int   bytes_offered = 0;

    header_scoreboard sb;

    ac4toc_byte_if byte_ch ();
    ac4toc_res_if  res_ch ();

    ac4_toc_header_parser DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .results (res_ch)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // idle rates: sender-light phase, receiver-light phase, then no idling
    function automatic int sender_idle_pct(int ph);
        return (ph == 0) ? 38 : (ph == 1) ? 71 : 0;
    endfunction

    function automatic int receiver_idle_pct(int ph);
        return (ph == 0) ? 71 : (ph == 1) ? 38 : 0;
    endfunction

    // one byte transfer, with idle cycles in front
    task automatic send_byte(logic [7:0] b, bit start, bit last);
        while ($urandom_range(0, 99) < sender_idle_pct(phase))
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.byte_value  <= b;
        byte_ch.frame_start <= start;
        byte_ch.frame_end   <= last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        bytes_offered++;
        sb.take_byte(b, start, last);
        if (bytes_offered >= 2 * ByteTarget / 3)
            phase = 2;
        else if (bytes_offered >= ByteTarget / 3)
            phase = 1;
    endtask

    // len bytes of a frame, trailing bytes past the header are random
    task automatic send_frame(hdr_bytes_t hdr, int len, bit close);
        for (int i = 0; i < len; i++)
            send_byte((i < HdrBytes) ? hdr[i] : 8'($urandom), i == 0, close && i == len - 1);
    endtask

    // lay out a header: optional sync word and length, then the toc fields
    function automatic hdr_bytes_t build_header(header_form_t form, bit alt_b1,
                                                int unsigned plen, logic [1:0] version,
                                                logic [9:0] seq, bit wflag, logic [2:0] wf,
                                                logic [1:0] resv, bit rate, logic [3:0] idx);
        hdr_bytes_t  h;
        int unsigned base;
        int unsigned acc;
        int          nb;
        foreach (h[i]) h[i] = 8'($urandom);
        base = 0;
        if (form != FORM_RAW)
        begin
            h[0] = SYNC_B0;
            h[1] = alt_b1 ? SYNC_B1_B : SYNC_B1_A;
        end
        if (form == FORM_SYNC_PLAIN)
        begin
            h[2] = plen[15:8];
            h[3] = plen[7:0];
            base = 4;
        end
        else if (form == FORM_SYNC_ESCAPED)
        begin
            h[2] = LEN_ESCAPE;
            h[3] = LEN_ESCAPE;
            h[4] = plen[23:16];
            h[5] = plen[15:8];
            h[6] = plen[7:0];
            base = 7;
        end
        // pack the toc fields msb first, random filler after them
        acc = {version, seq};
        nb = 12;
        acc = (acc << 1) | wflag;
        nb += 1;
        if (wflag)
        begin
            acc = (acc << 3) | wf;
            nb += 3;
            if (wf != 0)
            begin
                acc = (acc << 2) | resv;
                nb += 2;
            end
        end
        acc = (acc << 5) | {rate, idx};
        nb += 5;
        acc = (acc << (24 - nb)) | ($urandom & ((32'd1 << (24 - nb)) - 1));
        h[base]     = acc[23:16];
        h[base + 1] = acc[15:8];
        h[base + 2] = acc[7:0];
        return h;
    endfunction

    // mostly well-formed frames, some short, cut off by a restart, or plain noise
    task automatic send_random_frame();
        header_form_t form;
        int unsigned  plen;
        bit           rate;
        logic [3:0]   idx;
        logic [2:0]   wf;
        hdr_bytes_t   h;
        int           pick;
        pick = $urandom_range(0, 99);
        form = (pick < 40) ? FORM_SYNC_PLAIN : (pick < 65) ? FORM_SYNC_ESCAPED : FORM_RAW;
        if ($urandom_range(0, 3) == 0)
            plen = $urandom_range(0, 4);
        else if (form == FORM_SYNC_ESCAPED)
            plen = $urandom_range(5, 24'hFFFFFF);
        else
            plen = $urandom_range(5, 16'hFFFF);
        rate = $urandom_range(0, 4) != 0;
        if ($urandom_range(0, 6) == 0)
            idx = 4'($urandom_range(14, 15));
        else
            idx = 4'($urandom_range(0, 13));
        if (!rate && $urandom_range(0, 1) == 1)
            idx = TOP_INDEX;
        wf = ($urandom_range(0, 1) == 1) ? 3'($urandom) : 3'd0;
        h = build_header(form, 1'($urandom), plen, 2'($urandom), 10'($urandom), 1'($urandom),
                         wf, 2'($urandom), rate, idx);
        // stray bytes between frames
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 70)
            send_frame(h, $urandom_range(10, 13), $urandom_range(0, 4) != 0);
        else if (pick < 82)
            send_frame(h, $urandom_range(1, 9), 1'b1);
        else if (pick < 92)
            send_frame(h, $urandom_range(1, 9), 1'b0);
        else
            repeat ($urandom_range(1, 5))
                send_byte(8'($urandom), $urandom_range(0, 4) == 0, $urandom_range(0, 2) == 0);
    endtask

    // result side: check each transfer, pick next ready
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
                sb.check_header(header_t'({res_ch.status, res_ch.is_sync_frame,
                                           res_ch.seq_number, res_ch.rate_is_48k,
                                           res_ch.frame_samples}));
            if (byte_ch.valid && !byte_ch.ready)
                stall_cycles++;
            res_ch.ready <= !hold_off && ($urandom_range(0, 99) >= receiver_idle_pct(phase));
        end
    end

    // long receiver hold-off once the sender stops idling, to back up the byte channel
    initial
    begin
        wait (phase == 2);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_off <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d headers pending", cycles, sb.pending.size());
            $display("status: fail");
            $finish;
        end
    end

    // main stimulus
    initial
    begin
        hdr_bytes_t h;
        sb = new();
        rst_n               <= 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.byte_value  <= '0;
        byte_ch.frame_start <= 1'b0;
        byte_ch.frame_end   <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes before any frame start are dropped
        send_byte(SYNC_B0, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        // sync, plain length, all toc fields at their top, end on the tenth byte
        h = build_header(FORM_SYNC_PLAIN, 1'b0, 16'h0100, 2'b11, 10'h3FF, 1'b1, 3'd7, 2'b11,
                         1'b1, TOP_INDEX);
        send_frame(h, 10, 1'b1);
        // sync, escaped length, toc fields at zero but the rate bit, trailing bytes ignored
        h = build_header(FORM_SYNC_ESCAPED, 1'b1, 24'h000100, 2'b00, 10'h000, 1'b0, 3'd0,
                         2'b00, 1'b1, 4'd0);
        send_frame(h, 12, 1'b1);
        // plain frame, index above the top one
        h = build_header(FORM_RAW, 1'b0, 0, 2'b11, 10'h3FF, 1'b1, 3'd7, 2'b11, 1'b1, 4'd15);
        send_frame(h, 10, 1'b1);
        // one-byte payload length: every field lies past the bound and reads as zero
        h = build_header(FORM_SYNC_PLAIN, 1'b1, 1, 2'b01, 10'h155, 1'b1, 3'd2, 2'b01, 1'b1,
                         4'd5);
        send_frame(h, 10, 1'b0);
        // bound cuts only the rate index
        h = build_header(FORM_SYNC_ESCAPED, 1'b0, 2, 2'b10, 10'h2AA, 1'b0, 3'd0, 2'b00, 1'b1,
                         4'd7);
        send_frame(h, 11, 1'b0);
        // 44.1k with the right index, then with a wrong one
        h = build_header(FORM_RAW, 1'b0, 0, 2'b00, 10'h000, 1'b0, 3'd0, 2'b00, 1'b0,
                         TOP_INDEX);
        send_frame(h, 10, 1'b1);
        h = build_header(FORM_SYNC_PLAIN, 1'b0, 16'hFFF0, 2'b00, 10'h0F0, 1'b1, 3'd0, 2'b00,
                         1'b0, 4'd4);
        send_frame(h, 10, 1'b1);
        // short frame, restart in the middle of a frame, single-byte frame
        send_frame(h, 3, 1'b1);
        send_frame(h, 5, 1'b0);
        send_frame(h, 1, 1'b1);

        // random frames
        while (bytes_offered < ByteTarget)
            send_random_frame();
        byte_ch.valid <= 1'b0;

        // drain, then keep watching for stray results
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("%0d byte transfers (%0d into frames), %0d headers: ok %0d, short %0d, %s",
                 bytes_offered, sb.bytes_taken, sb.headers_checked, sb.status_seen[ST_OK],
                 sb.status_seen[ST_SHORT], "index errors as below");
        $display("bad index %0d, 44.1k index %0d, sync frames %0d, input stalled %0d cycles",
                 sb.status_seen[ST_BAD_INDEX], sb.status_seen[ST_BAD_441], sb.sync_seen,
                 stall_cycles);
        if (sb.failures == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
src/ac4toc_pkg.sv
src/ac4toc_if.sv
src/ac4toc_front.sv
src/ac4toc_queue.sv
src/ac4toc_back.sv
src/ac4_toc_header_parser.sv
dv/ac4toc_tb_pkg.sv
dv/tb_top.sv
